// ===== hdl/vrp_pkg.sv =====
// types, constants and rounding helper for the vertex rotate/project pipeline
// no dependencies; used by vrp_div_lane and vertex_rotate_project_top
package vrp_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int TRIG_WIDTH  = 16;
    localparam int FRAC_TRIG   = 14;
    localparam int PROD_WIDTH  = COORD_WIDTH + TRIG_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;
    localparam int REG_WIDTH   = 10;
    localparam int SCR_WIDTH   = 12;
    localparam int NUM_WIDTH   = COORD_WIDTH + REG_WIDTH;
    localparam int DEN_WIDTH   = REG_WIDTH + 8 + 1;
    localparam int DIV_BITS    = SCR_WIDTH;
    localparam int SH_WIDTH    = DEN_WIDTH + DIV_BITS;

    localparam logic [1:0] REG_FOCAL_SCALE = 2'd0;
    localparam logic [1:0] REG_CENTER_X    = 2'd1;
    localparam logic [1:0] REG_CENTER_Y    = 2'd2;

    localparam logic [REG_WIDTH-1:0] FOCAL_RESET    = REG_WIDTH'(200);
    localparam logic [REG_WIDTH-1:0] CENTER_X_RESET = REG_WIDTH'(160);
    localparam logic [REG_WIDTH-1:0] CENTER_Y_RESET = REG_WIDTH'(128);

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
    } vrp_in_t;

    typedef struct packed {
        logic signed [SCR_WIDTH-1:0] screen_x;
        logic signed [SCR_WIDTH-1:0] screen_y;
        logic                        behind_viewer;
    } vrp_out_t;

    // round half up to q8.8 and saturate to the coordinate width
    function automatic logic signed [COORD_WIDTH-1:0] mix_round(
        input logic signed [ACC_WIDTH-1:0] acc
    );
        logic signed [ACC_WIDTH-1:0] sh;
        logic signed [ACC_WIDTH-1:0] lim;
        lim = ACC_WIDTH'(1) <<< (COORD_WIDTH - 1);
        sh  = (acc + (ACC_WIDTH'(1) <<< (FRAC_TRIG - 1))) >>> FRAC_TRIG;
        if (sh > lim - ACC_WIDTH'(1))
            return COORD_WIDTH'(lim - ACC_WIDTH'(1));
        else if (sh < -lim)
            return COORD_WIDTH'(-lim);
        else
            return COORD_WIDTH'(sh);
    endfunction

endpackage

// ===== hdl/vrp_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on vrp_pkg
module vrp_div_lane (
    input  logic                         clk,
    input  logic                         ce,
    input  logic [vrp_pkg::NUM_WIDTH-1:0] num,
    input  logic [vrp_pkg::DEN_WIDTH-1:0] den,
    output logic [vrp_pkg::DIV_BITS-1:0]  quot,
    output logic                          ovf
);
    import vrp_pkg::*;

    logic [NUM_WIDTH-1:0] rem_reg [0:DIV_BITS-1];
    logic [DEN_WIDTH-1:0] den_reg [0:DIV_BITS-1];
    logic [DIV_BITS-1:0]  q_reg   [0:DIV_BITS];
    logic                 ovf_reg [0:DIV_BITS];

    // quotient too big for the screen range when num >= den << DIV_BITS
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (SH_WIDTH'(num) >= (SH_WIDTH'(den) << DIV_BITS));
        end
    end

    for (genvar k = 1; k <= DIV_BITS; k++)
    begin : g_stage
        localparam int B = DIV_BITS - k;
        logic [SH_WIDTH-1:0] dsh;
        logic                take;
        assign dsh  = SH_WIDTH'(den_reg[k-1]) << B;
        assign take = (SH_WIDTH'(rem_reg[k-1]) >= dsh);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                q_reg[k]   <= q_reg[k-1] | (DIV_BITS'(take) << B);
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        // the last stage only needs its quotient bit
        if (k < DIV_BITS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k] <= take ? NUM_WIDTH'(SH_WIDTH'(rem_reg[k-1]) - dsh)
                                       : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quot = q_reg[DIV_BITS];
    assign ovf  = ovf_reg[DIV_BITS];

endmodule

// ===== hdl/vertex_rotate_project_top.sv =====
// vertex rotation about x, y, z and perspective projection, top level
// depends on vrp_pkg and vrp_div_lane
//
// One vertex word in, one screen word out, one word per clock while the
// pipeline is not held. Six register stages serve the three rotations
// (multiply, then add/round), two the depth and numerator products, thirteen the
// bit-per-stage divider and one the output register. The whole pipeline holds
// while out_stall is high and a result waits. Register writes are taken at
// any time and should be made only while no vertex is in flight.
module vertex_rotate_project_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  vrp_pkg::vrp_in_t                  in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output vrp_pkg::vrp_out_t                 out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [vrp_pkg::REG_WIDTH-1:0]     cfg_data
);
    import vrp_pkg::*;

    localparam int NV = 7;

    typedef struct packed {
        logic vld;
        logic behind;
        logic neg_x;
        logic neg_y;
    } side_t;

    logic ce;
    logic [REG_WIDTH-1:0] focal_reg, cx_reg, cy_reg;
    logic [NV-1:0] v_reg;

    logic signed [15:0] c_reg [1:4];
    logic signed [15:0] s_reg [1:4];

    // stage 1/2: about x
    logic signed [COORD_WIDTH-1:0] x1_reg, y2_reg, z2_reg, x2_reg;
    logic signed [PROD_WIDTH-1:0]  a1_reg, b1_reg, c1_reg, d1_reg;
    // stage 3/4: about y
    logic signed [PROD_WIDTH-1:0]  a3_reg, b3_reg, c3_reg, d3_reg;
    logic signed [COORD_WIDTH-1:0] y3_reg, x4_reg, z4_reg, y4_reg;
    // stage 5/6: about z
    logic signed [PROD_WIDTH-1:0]  a5_reg, b5_reg, c5_reg, d5_reg;
    logic signed [COORD_WIDTH-1:0] z5_reg, x6_reg, y6_reg, z6_reg;
    // stage 7/8: projection setup
    logic signed [DEN_WIDTH:0]     den7_reg;
    logic signed [NUM_WIDTH:0]     nx7_reg, ny7_reg;
    logic [NUM_WIDTH-1:0]          nx8_reg, ny8_reg;
    logic [DEN_WIDTH-1:0]          den8_reg;
    side_t                         side8_reg;
    side_t                         side_reg [0:DIV_BITS];

    logic [DIV_BITS-1:0] qx, qy;
    logic                ovx, ovy;
    vrp_out_t            out_reg;
    logic                out_valid_reg;

    assign ce        = !(out_valid_reg && out_stall);
    assign in_stall  = !ce;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg <= FOCAL_RESET;
            cx_reg    <= CENTER_X_RESET;
            cy_reg    <= CENTER_Y_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FOCAL_SCALE: focal_reg <= cfg_data;
                REG_CENTER_X:    cx_reg    <= cfg_data;
                REG_CENTER_Y:    cy_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[NV-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c_reg[1] <= in_word.cos_angle;
            s_reg[1] <= in_word.sin_angle;
            for (int i = 2; i <= 4; i++)
            begin
                c_reg[i] <= c_reg[i-1];
                s_reg[i] <= s_reg[i-1];
            end
            // about x
            a1_reg <= in_word.cos_angle * COORD_WIDTH'(in_word.pos_y);
            b1_reg <= in_word.sin_angle * COORD_WIDTH'(in_word.pos_z);
            c1_reg <= in_word.sin_angle * COORD_WIDTH'(in_word.pos_y);
            d1_reg <= in_word.cos_angle * COORD_WIDTH'(in_word.pos_z);
            x1_reg <= COORD_WIDTH'(in_word.pos_x);
            y2_reg <= mix_round(ACC_WIDTH'(a1_reg) - ACC_WIDTH'(b1_reg));
            z2_reg <= mix_round(ACC_WIDTH'(c1_reg) + ACC_WIDTH'(d1_reg));
            x2_reg <= x1_reg;
            // about y
            a3_reg <= c_reg[2] * x2_reg;
            b3_reg <= s_reg[2] * z2_reg;
            c3_reg <= c_reg[2] * z2_reg;
            d3_reg <= s_reg[2] * x2_reg;
            y3_reg <= y2_reg;
            x4_reg <= mix_round(ACC_WIDTH'(a3_reg) + ACC_WIDTH'(b3_reg));
            z4_reg <= mix_round(ACC_WIDTH'(c3_reg) - ACC_WIDTH'(d3_reg));
            y4_reg <= y3_reg;
            // about z
            a5_reg <= c_reg[4] * x4_reg;
            b5_reg <= s_reg[4] * y4_reg;
            c5_reg <= s_reg[4] * x4_reg;
            d5_reg <= c_reg[4] * y4_reg;
            z5_reg <= z4_reg;
            x6_reg <= mix_round(ACC_WIDTH'(a5_reg) - ACC_WIDTH'(b5_reg));
            y6_reg <= mix_round(ACC_WIDTH'(c5_reg) + ACC_WIDTH'(d5_reg));
            z6_reg <= z5_reg;
            // depth plus scale in q8.8, numerators in q8.8 times scale
            den7_reg <= (DEN_WIDTH+1)'(z6_reg)
                      + $signed({1'b0, focal_reg, 8'b0});
            nx7_reg  <= (NUM_WIDTH+1)'(x6_reg) * $signed({1'b0, focal_reg});
            ny7_reg  <= (NUM_WIDTH+1)'(y6_reg) * $signed({1'b0, focal_reg});
            // magnitudes for the unsigned divider
            nx8_reg  <= NUM_WIDTH'(nx7_reg[NUM_WIDTH] ? -nx7_reg : nx7_reg);
            ny8_reg  <= NUM_WIDTH'(ny7_reg[NUM_WIDTH] ? -ny7_reg : ny7_reg);
            den8_reg <= DEN_WIDTH'(den7_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side8_reg <= '0;
        else if (ce)
        begin
            side8_reg.vld    <= v_reg[6];
            side8_reg.behind <= (den7_reg <= 0);
            side8_reg.neg_x  <= nx7_reg[NUM_WIDTH];
            side8_reg.neg_y  <= ny7_reg[NUM_WIDTH];
        end
    end

    vrp_div_lane u_div_x (
        .clk  (clk),
        .ce   (ce),
        .num  (nx8_reg),
        .den  (den8_reg),
        .quot (qx),
        .ovf  (ovx)
    );

    vrp_div_lane u_div_y (
        .clk  (clk),
        .ce   (ce),
        .num  (ny8_reg),
        .den  (den8_reg),
        .quot (qy),
        .ovf  (ovy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_BITS; i++)
                side_reg[i] <= '0;
        end
        else if (ce)
        begin
            side_reg[0] <= side8_reg;
            for (int i = 1; i <= DIV_BITS; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // clamp the quotient, restore sign, add center, saturate
    function automatic logic signed [SCR_WIDTH-1:0] finish(
        input logic [DIV_BITS-1:0]  q,
        input logic                 ov,
        input logic                 neg,
        input logic [REG_WIDTH-1:0] ctr
    );
        logic signed [SCR_WIDTH+1:0] mag;
        logic signed [SCR_WIDTH+1:0] sum;
        mag = ov ? (SCR_WIDTH+2)'({DIV_BITS{1'b1}}) : (SCR_WIDTH+2)'(q);
        sum = (neg ? -mag : mag) + $signed((SCR_WIDTH+2)'(ctr));
        if (sum > (SCR_WIDTH+2)'(2047))
            return SCR_WIDTH'(2047);
        else if (sum < -(SCR_WIDTH+2)'(2048))
            return SCR_WIDTH'(-2048);
        else
            return SCR_WIDTH'(sum);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= side_reg[DIV_BITS].vld;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_reg.behind_viewer <= side_reg[DIV_BITS].behind;
            if (side_reg[DIV_BITS].behind)
            begin
                out_reg.screen_x <= '0;
                out_reg.screen_y <= '0;
            end
            else
            begin
                out_reg.screen_x <= finish(qx, ovx, side_reg[DIV_BITS].neg_x, cx_reg);
                out_reg.screen_y <= finish(qy, ovy, side_reg[DIV_BITS].neg_y, cy_reg);
            end
        end
    end

endmodule
